@@ design/dtd_pkg.sv @@
`timescale 1ns / 1ps
package dtd_pkg;

  localparam logic [15:0] COUNT_MAX    = 16'd65535;
  localparam logic [8:0]  EXPONENT_MAX = 9'd511;
  localparam int          QDEPTH       = 4;
  localparam int          QPTR_W       = $clog2(QDEPTH);

  localparam logic [63:0] DBL_ZERO  = 64'h0000_0000_0000_0000;
  localparam logic [63:0] DBL_ONE   = 64'h3FF0_0000_0000_0000;
  localparam logic [63:0] DBL_TEN   = 64'h4024_0000_0000_0000;
  localparam logic [63:0] DBL_TENTH = 64'h3FB9_9999_9999_999A;
  localparam logic [63:0] DBL_INF   = 64'h7FF0_0000_0000_0000;
  localparam logic [63:0] DBL_DNAN  = 64'hFFF8_0000_0000_0000;
  localparam logic [63:0] DBL_QBIT  = 64'h0008_0000_0000_0000;

  typedef enum logic [1:0] {
    CMD_INT_DIGIT,
    CMD_FRAC_DIGIT,
    CMD_FRAC_START,
    CMD_FINISH
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [3:0]  digit;
    logic        negative;
    logic        zero;
    logic [8:0]  exp_count;
    logic        exp_negative;
    logic [15:0] count;
  } cmd_t;

  typedef enum logic {
    OP_MUL,
    OP_ADD
  } fpu_op_t;

  // exact binary64 value of a decimal digit
  function automatic logic [63:0] digit_to_dbl(input logic [3:0] d);
    logic [63:0] r;
    unique case (d)
      4'd0:    r = 64'h0000_0000_0000_0000;
      4'd1:    r = 64'h3FF0_0000_0000_0000;
      4'd2:    r = 64'h4000_0000_0000_0000;
      4'd3:    r = 64'h4008_0000_0000_0000;
      4'd4:    r = 64'h4010_0000_0000_0000;
      4'd5:    r = 64'h4014_0000_0000_0000;
      4'd6:    r = 64'h4018_0000_0000_0000;
      4'd7:    r = 64'h401C_0000_0000_0000;
      4'd8:    r = 64'h4020_0000_0000_0000;
      4'd9:    r = 64'h4022_0000_0000_0000;
      default: r = 64'h0000_0000_0000_0000;
    endcase
    return r;
  endfunction

endpackage

@@ design/decimal_text_to_double_top.sv @@
`timescale 1ns / 1ps
// decimal text to binary64, one byte per transfer; a result leaves on the terminating byte
// bytes are taken one per cycle while the 4-entry command queue has room
// back end: an integer digit is a multiply and an add, a fraction digit also a scale step
// terminator: up to 9 multiplies and 8 squarings before the output register
// subnormal operands or results add normalize shifts to each fp operation
// rst is synchronous, active high: clears parse state, queue fill and output valid
module decimal_text_to_double_top import dtd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // ch[7:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata    // value_bits[63:0], end_offset[79:64]
);

  // front to queue
  logic push, q_full;
  cmd_t cmd_in;

  // queue to back
  logic q_valid, pop;
  cmd_t cmd_out;

  logic [63:0] value_bits;
  logic [15:0] end_offset;

  // parser: whitespace, sign, digits, exponent; emits float work commands
  dtd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .ch       (s_tdata),
    .q_full   (q_full),
    .push     (push),
    .cmd      (cmd_in)
  );

  // short queue so parsing runs ahead of the float unit
  dtd_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .cmd_in  (cmd_in),
    .full    (q_full),
    .pop     (pop),
    .valid   (q_valid),
    .cmd_out (cmd_out)
  );

  // float sequencer with shared multiply/add unit and output register
  dtd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_cmd      (cmd_out),
    .pop        (pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .value_bits (value_bits),
    .end_offset (end_offset)
  );

  assign m_tdata = {end_offset, value_bits};

endmodule

@@ design/dtd_front.sv @@
`timescale 1ns / 1ps
module dtd_front import dtd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] ch,
  input  logic       q_full,
  output logic       push,
  output cmd_t       cmd
);

  typedef enum logic [2:0] {
    P_SPACE,
    P_INT,
    P_FRAC,
    P_ESTART,
    P_EDIG
  } phase_t;

  phase_t      phase, phase_next, ph;
  logic        negative, negative_next;
  logic [8:0]  exp_count, exp_count_next;
  logic        exp_neg, exp_neg_next;
  logic [15:0] byte_count, byte_count_next;

  logic        is_ws, is_dig, is_sign, is_e, is_dot;
  logic [3:0]  dig;
  logic [12:0] exp_acc;
  logic        bump, fin, fin_zero, gen;
  logic        accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  assign is_ws   = (ch == 8'd32) || (ch >= 8'd9 && ch <= 8'd13);
  assign is_dig  = (ch >= 8'd48) && (ch <= 8'd57);
  assign is_sign = (ch == 8'd45) || (ch == 8'd43);
  assign is_e    = ((ch | 8'd32) == 8'd101);
  assign is_dot  = (ch == 8'd46);
  assign dig     = 4'(ch - 8'd48);
  assign exp_acc = 13'({4'b0, exp_count} * 13'd10) + {9'b0, dig};

  always_comb begin
    phase_next      = phase;
    negative_next   = negative;
    exp_count_next  = exp_count;
    exp_neg_next    = exp_neg;
    bump            = 1'b0;
    fin             = 1'b0;
    fin_zero        = 1'b0;
    gen             = 1'b0;
    cmd             = '0;
    cmd.kind        = CMD_FINISH;
    ph              = (phase == P_SPACE) ? P_INT : phase;
    if (phase == P_SPACE && is_ws) begin
      bump = 1'b1;
    end else if (phase == P_SPACE && is_sign) begin
      negative_next = (ch == 8'd45);
      phase_next    = P_INT;
      bump          = 1'b1;
    end else begin
      // the first byte that is not whitespace leaves the whitespace phase
      phase_next = ph;
      unique case (ph)
        P_INT: begin
          if (is_dig) begin
            gen = 1'b1; cmd.kind = CMD_INT_DIGIT; cmd.digit = dig; bump = 1'b1;
          end else if (is_dot) begin
            gen = 1'b1; cmd.kind = CMD_FRAC_START; phase_next = P_FRAC; bump = 1'b1;
          end else if (is_e) begin
            phase_next = P_ESTART; bump = 1'b1;
          end else begin
            fin = 1'b1;
          end
        end
        P_FRAC: begin
          if (is_dig) begin
            gen = 1'b1; cmd.kind = CMD_FRAC_DIGIT; cmd.digit = dig; bump = 1'b1;
          end else if (is_e) begin
            phase_next = P_ESTART; bump = 1'b1;
          end else begin
            fin = 1'b1;
          end
        end
        P_ESTART: begin
          if (is_sign) begin
            exp_neg_next = (ch == 8'd45); phase_next = P_EDIG; bump = 1'b1;
          end else if (is_dig) begin
            exp_count_next = (exp_acc > {4'b0, EXPONENT_MAX}) ? EXPONENT_MAX : exp_acc[8:0];
            phase_next     = P_EDIG;
            bump           = 1'b1;
          end else begin
            fin = 1'b1; fin_zero = 1'b1;
          end
        end
        P_EDIG: begin
          if (is_dig) begin
            exp_count_next = (exp_acc > {4'b0, EXPONENT_MAX}) ? EXPONENT_MAX : exp_acc[8:0];
            bump           = 1'b1;
          end else begin
            fin = 1'b1;
          end
        end
        default: begin
          fin = 1'b1;
        end
      endcase
    end

    byte_count_next = byte_count;
    if (bump && byte_count != COUNT_MAX) byte_count_next = byte_count + 16'd1;

    if (fin) begin
      gen              = 1'b1;
      cmd.kind         = CMD_FINISH;
      cmd.negative     = negative;
      cmd.zero         = fin_zero;
      cmd.exp_count    = exp_count;
      cmd.exp_negative = exp_neg;
      cmd.count        = fin_zero ? 16'd0 : byte_count;
      phase_next       = P_SPACE;
      negative_next    = 1'b0;
      exp_count_next   = 9'd0;
      exp_neg_next     = 1'b0;
      byte_count_next  = 16'd0;
    end
  end

  assign push = accept && gen;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= P_SPACE;
      negative   <= 1'b0;
      exp_count  <= 9'd0;
      exp_neg    <= 1'b0;
      byte_count <= 16'd0;
    end else if (accept) begin
      phase      <= phase_next;
      negative   <= negative_next;
      exp_count  <= exp_count_next;
      exp_neg    <= exp_neg_next;
      byte_count <= byte_count_next;
    end
  end

endmodule

@@ design/dtd_queue.sv @@
`timescale 1ns / 1ps
module dtd_queue import dtd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t cmd_in,
  output logic full,
  input  logic pop,
  output logic valid,
  output cmd_t cmd_out
);

  cmd_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QPTR_W:0]   fill;

  assign full    = (fill == (QPTR_W+1)'(QDEPTH));
  assign valid   = (fill != '0);
  assign cmd_out = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= cmd_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      fill <= fill + 1'b1;
      else if (pop && !push) fill <= fill - 1'b1;
    end
  end

endmodule

@@ design/dtd_fpu.sv @@
`timescale 1ns / 1ps
module dtd_fpu import dtd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  fpu_op_t     op,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic        done,
  output logic [63:0] res
);

  // operands are non-negative or nan; rounding is nearest even

  typedef enum logic [2:0] {
    F_IDLE,
    F_MUL,
    F_NORM,
    F_ROUND,
    F_DONE
  } fstate_t;

  fstate_t state;

  logic [10:0] ea, eb, eaa, ebb;
  logic [51:0] fa, fb;
  logic [52:0] ma, mb;
  logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;

  assign ea = a[62:52];
  assign eb = b[62:52];
  assign fa = a[51:0];
  assign fb = b[51:0];
  assign a_nan  = (&ea) && (|fa);
  assign b_nan  = (&eb) && (|fb);
  assign a_inf  = (&ea) && !(|fa);
  assign b_inf  = (&eb) && !(|fb);
  assign a_zero = (ea == 11'd0) && (fa == 52'd0);
  assign b_zero = (eb == 11'd0) && (fb == 52'd0);
  assign ma  = {|ea, fa};
  assign mb  = {|eb, fb};
  assign eaa = (ea == 11'd0) ? 11'd1 : ea;
  assign ebb = (eb == 11'd0) ? 11'd1 : eb;

  // alignment for the adder
  logic        a_big;
  logic [52:0] hi_m, lo_m;
  logic [10:0] hi_e, lo_e, diff;
  logic [6:0]  dsh;
  logic [105:0] lo_full, add_sum;
  logic        add_st;

  assign a_big   = (eaa >= ebb);
  assign hi_m    = a_big ? ma : mb;
  assign lo_m    = a_big ? mb : ma;
  assign hi_e    = a_big ? eaa : ebb;
  assign lo_e    = a_big ? ebb : eaa;
  assign diff    = hi_e - lo_e;
  assign dsh     = (diff > 11'd106) ? 7'd106 : diff[6:0];
  assign lo_full = {1'b0, lo_m, 52'b0};
  assign add_sum = {1'b0, hi_m, 52'b0} + (lo_full >> dsh);
  assign add_st  = |(lo_full & ~({106{1'b1}} << dsh));

  // partial products of the mantissa multiply
  logic [52:0]  ma_r, mb_r;
  logic [2:0]   k, kp;
  logic [26:0]  px, py;
  logic [53:0]  prod, pp;
  logic [6:0]   psh;

  assign px   = (k == 3'd2 || k == 3'd3) ? ma_r[52:26] : {1'b0, ma_r[25:0]};
  assign py   = (k == 3'd1 || k == 3'd3) ? mb_r[52:26] : {1'b0, mb_r[25:0]};
  assign prod = px * py;
  assign kp   = k - 3'd1;
  assign psh  = (kp == 3'd0) ? 7'd0 : ((kp == 3'd3) ? 7'd52 : 7'd26);

  // working value: m with msb weight 2^(e-1023)
  logic [105:0]       m;
  logic signed [13:0] e;
  logic               st;

  // final rounding
  logic signed [13:0] amt, ee, ee_f;
  logic [6:0]         rs;
  logic [105:0]       m_r;
  logic               st_r, g, s, inc;
  logic [52:0]        mant, mant_f;
  logic [53:0]        sum54;
  logic [63:0]        rnd_res;

  always_comb begin
    amt   = 14'sd1 - e;
    rs    = (e >= 14'sd1) ? 7'd0 : ((amt > 14'sd106) ? 7'd106 : amt[6:0]);
    m_r   = m >> rs;
    st_r  = st | (|(m & ~({106{1'b1}} << rs)));
    mant  = m_r[105:53];
    g     = m_r[52];
    s     = st_r | (|m_r[51:0]);
    inc   = g && (s || mant[0]);
    sum54 = {1'b0, mant} + {53'b0, inc};
    ee    = (e < 14'sd1) ? 14'sd1 : e;
    if (sum54[53]) begin
      mant_f = sum54[53:1];
      ee_f   = ee + 14'sd1;
    end else begin
      mant_f = sum54[52:0];
      ee_f   = ee;
    end
    if (ee_f >= 14'sd2047) rnd_res = DBL_INF;
    else rnd_res = {1'b0, (mant_f[52] ? ee_f[10:0] : 11'd0), mant_f[51:0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      done  <= 1'b0;
    end else begin
      done <= (state == F_DONE);
      unique case (state)
        F_IDLE: begin
          if (start) begin
            if (a_nan) begin
              res <= a | DBL_QBIT; state <= F_DONE;
            end else if (b_nan) begin
              res <= b | DBL_QBIT; state <= F_DONE;
            end else if (op == OP_MUL) begin
              if ((a_inf && b_zero) || (b_inf && a_zero)) begin
                res <= DBL_DNAN; state <= F_DONE;
              end else if (a_inf || b_inf) begin
                res <= DBL_INF; state <= F_DONE;
              end else if (a_zero || b_zero) begin
                res <= DBL_ZERO; state <= F_DONE;
              end else begin
                ma_r  <= ma;
                mb_r  <= mb;
                m     <= '0;
                st    <= 1'b0;
                k     <= 3'd0;
                e     <= $signed({3'b0, eaa}) + $signed({3'b0, ebb}) - 14'sd1022;
                state <= F_MUL;
              end
            end else begin
              if (a_inf || b_inf) begin
                res <= DBL_INF; state <= F_DONE;
              end else if (a_zero) begin
                res <= b; state <= F_DONE;
              end else if (b_zero) begin
                res <= a; state <= F_DONE;
              end else begin
                m     <= add_sum;
                st    <= add_st;
                e     <= $signed({3'b0, hi_e}) + 14'sd1;
                state <= F_NORM;
              end
            end
          end
        end
        F_MUL: begin
          if (k != 3'd4) pp <= prod;
          if (k != 3'd0) m <= m + ({52'b0, pp} << psh);
          k <= k + 3'd1;
          if (k == 3'd4) state <= F_NORM;
        end
        F_NORM: begin
          // one bit per cycle, stops at the subnormal floor
          if (!m[105] && e > 14'sd1) begin
            m <= {m[104:0], 1'b0};
            e <= e - 14'sd1;
          end else begin
            state <= F_ROUND;
          end
        end
        F_ROUND: begin
          res   <= rnd_res;
          state <= F_DONE;
        end
        F_DONE: begin
          state <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

@@ design/dtd_back.sv @@
`timescale 1ns / 1ps
module dtd_back import dtd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  cmd_t        q_cmd,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] value_bits,
  output logic [15:0] end_offset
);

  typedef enum logic [3:0] {
    B_IDLE,
    B_INT_MUL,
    B_INT_ADD,
    B_FR_SCALE,
    B_FR_MUL,
    B_FR_ADD,
    B_EXP_A,
    B_EXP_B,
    B_EXP_C,
    B_OUT
  } bstate_t;

  bstate_t     state;
  cmd_t        cur;
  logic [63:0] acc, scale, tmp, fac;
  logic [8:0]  ecnt;
  logic        issued;
  logic        issue;

  logic        f_start, f_done;
  fpu_op_t     f_op;
  logic [63:0] f_a, f_b, f_res;

  dtd_fpu u_fpu (
    .clk   (clk),
    .rst   (rst),
    .start (f_start),
    .op    (f_op),
    .a     (f_a),
    .b     (f_b),
    .done  (f_done),
    .res   (f_res)
  );

  assign pop = (state == B_IDLE) && q_valid;

  // each op state launches its float operation first (B_EXP_A: if ecnt[0])
  assign issue = !issued &&
                 ((state == B_INT_MUL) || (state == B_INT_ADD) || (state == B_FR_SCALE) ||
                  (state == B_FR_MUL) || (state == B_FR_ADD) || (state == B_EXP_C) ||
                  (state == B_EXP_A && ecnt[0]));

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      issued    <= 1'b0;
      f_start   <= 1'b0;
      out_valid <= 1'b0;
      acc       <= DBL_ZERO;
      scale     <= DBL_ONE;
    end else begin
      f_start <= issue;
      if (out_valid && out_ready && state != B_OUT) out_valid <= 1'b0;
      unique case (state)
        B_IDLE: begin
          if (q_valid) begin
            cur <= q_cmd;
            unique case (q_cmd.kind)
              CMD_INT_DIGIT:  state <= B_INT_MUL;
              CMD_FRAC_DIGIT: state <= B_FR_SCALE;
              CMD_FRAC_START: scale <= DBL_ONE;
              CMD_FINISH: begin
                if (q_cmd.zero) begin
                  acc   <= DBL_ZERO;
                  state <= B_OUT;
                end else begin
                  fac   <= q_cmd.exp_negative ? DBL_TENTH : DBL_TEN;
                  ecnt  <= q_cmd.exp_count;
                  state <= B_EXP_A;
                end
              end
              default: state <= B_IDLE;
            endcase
          end
        end
        B_INT_MUL: begin
          if (!issued) begin
            f_a <= acc; f_b <= DBL_TEN; f_op <= OP_MUL; issued <= 1'b1;
          end else if (f_done) begin
            tmp <= f_res; issued <= 1'b0; state <= B_INT_ADD;
          end
        end
        B_INT_ADD: begin
          if (!issued) begin
            f_a <= tmp; f_b <= digit_to_dbl(cur.digit); f_op <= OP_ADD;
            issued <= 1'b1;
          end else if (f_done) begin
            acc <= f_res; issued <= 1'b0; state <= B_IDLE;
          end
        end
        B_FR_SCALE: begin
          if (!issued) begin
            f_a <= scale; f_b <= DBL_TENTH; f_op <= OP_MUL; issued <= 1'b1;
          end else if (f_done) begin
            scale <= f_res; issued <= 1'b0; state <= B_FR_MUL;
          end
        end
        B_FR_MUL: begin
          if (!issued) begin
            f_a <= digit_to_dbl(cur.digit); f_b <= scale; f_op <= OP_MUL;
            issued <= 1'b1;
          end else if (f_done) begin
            tmp <= f_res; issued <= 1'b0; state <= B_FR_ADD;
          end
        end
        B_FR_ADD: begin
          if (!issued) begin
            f_a <= acc; f_b <= tmp; f_op <= OP_ADD; issued <= 1'b1;
          end else if (f_done) begin
            acc <= f_res; issued <= 1'b0; state <= B_IDLE;
          end
        end
        B_EXP_A: begin
          // multiply in the current power when its exponent bit is set
          if (!ecnt[0]) begin
            state <= B_EXP_B;
          end else if (!issued) begin
            f_a <= acc; f_b <= fac; f_op <= OP_MUL; issued <= 1'b1;
          end else if (f_done) begin
            acc <= f_res; issued <= 1'b0; state <= B_EXP_B;
          end
        end
        B_EXP_B: begin
          ecnt <= {1'b0, ecnt[8:1]};
          if (ecnt[8:1] == 8'd0) state <= B_OUT;
          else state <= B_EXP_C;
        end
        B_EXP_C: begin
          if (!issued) begin
            f_a <= fac; f_b <= fac; f_op <= OP_MUL; issued <= 1'b1;
          end else if (f_done) begin
            fac <= f_res; issued <= 1'b0; state <= B_EXP_A;
          end
        end
        B_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid  <= 1'b1;
            value_bits <= acc ^ {cur.negative, 63'b0};
            end_offset <= cur.count;
            acc        <= DBL_ZERO;
            scale      <= DBL_ONE;
            state      <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
  import dtd_pkg::*;

  typedef enum int {
    SCAN_SPACE,
    SCAN_INT,
    SCAN_FRAC,
    SCAN_EXP_START,
    SCAN_EXP_DIGITS
  } scan_phase_t;

  typedef struct packed {
    logic [63:0] value_bits;
    logic [15:0] end_offset;
  } conversion_t;

  localparam longint CYCLE_LIMIT = 4000000;
  localparam int     DRAIN_CYCLES = 400;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [79:0] m_tdata;

  // idle percentages for each side, and a long receiver hold-off
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned recv_hold = 0;

  // converter state as seen by the predictor
  scan_phase_t scan_phase;
  bit          text_negative;
  real         running_value;
  real         digit_scale;
  int unsigned exp_value;
  bit          exp_negative;
  int unsigned bytes_taken;

  conversion_t pending_conversions[$];
  int          mismatch_count = 0;
  longint      cycle_count = 0;

  decimal_text_to_double_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("decimal_text_to_double_top test failed");
      $finish;
    end
  end

  function automatic void clear_scan();
    scan_phase    = SCAN_SPACE;
    text_negative = 1'b0;
    running_value = 0.0;
    digit_scale   = 1.0;
    exp_value     = 0;
    exp_negative  = 1'b0;
    bytes_taken   = 0;
  endfunction

  function automatic void count_byte();
    if (bytes_taken < COUNT_MAX) bytes_taken++;
  endfunction

  function automatic bit is_decimal(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  // scale by ten to the exponent with square and multiply
  function automatic real scale_by_exponent(input real v);
    real f;
    int unsigned e;
    f = exp_negative ? $bitstoreal(DBL_TENTH) : 10.0;
    e = exp_value;
    forever begin
      if (e[0]) v = v * f;
      e = e >> 1;
      if (e == 0) break;
      f = f * f;
    end
    return v;
  endfunction

  function automatic void emit_conversion(input real v, input int unsigned offset);
    conversion_t r;
    logic [63:0] b;
    b = $realtobits(v);
    // invalid products come out as the default nan
    if (b[62:52] == 11'h7FF && b[51:0] != 52'd0) b = DBL_DNAN;
    if (text_negative) b[63] = ~b[63];
    r.value_bits = b;
    r.end_offset = offset[15:0];
    pending_conversions.push_back(r);
    clear_scan();
  endfunction

  // one byte into the predictor, possibly producing a conversion
  function automatic void scan_byte(input logic [7:0] c);
    if (scan_phase == SCAN_SPACE) begin
      if (c == 8'd32 || (c >= 8'd9 && c <= 8'd13)) begin
        count_byte();
        return;
      end
      scan_phase = SCAN_INT;
      if (c == "-" || c == "+") begin
        text_negative = (c == "-");
        count_byte();
        return;
      end
    end
    case (scan_phase)
      SCAN_INT: begin
        if (is_decimal(c)) begin
          running_value = running_value * 10.0;
          running_value = running_value + real'(c - 8'd48);
          count_byte();
        end else if (c == ".") begin
          digit_scale = 1.0;
          scan_phase = SCAN_FRAC;
          count_byte();
        end else if ((c | 8'd32) == "e") begin
          scan_phase = SCAN_EXP_START;
          count_byte();
        end else begin
          emit_conversion(running_value, bytes_taken);
        end
        return;
      end
      SCAN_FRAC: begin
        if (is_decimal(c)) begin
          digit_scale = digit_scale * $bitstoreal(DBL_TENTH);
          running_value = running_value + real'(c - 8'd48) * digit_scale;
          count_byte();
        end else if ((c | 8'd32) == "e") begin
          scan_phase = SCAN_EXP_START;
          count_byte();
        end else begin
          emit_conversion(running_value, bytes_taken);
        end
        return;
      end
      SCAN_EXP_START: begin
        if (c == "-" || c == "+") begin
          exp_negative = (c == "-");
          scan_phase = SCAN_EXP_DIGITS;
          count_byte();
          return;
        end
        if (!is_decimal(c)) begin
          // bad exponent start gives signed zero and offset zero
          emit_conversion(0.0, 0);
          return;
        end
        scan_phase = SCAN_EXP_DIGITS;
      end
      default: ;
    endcase
    // exponent digits, the first one possibly coming straight from the exponent start
    if (is_decimal(c)) begin
      exp_value = exp_value * 10 + 32'(c - 8'd48);
      if (exp_value > 32'(EXPONENT_MAX)) exp_value = 32'(EXPONENT_MAX);
      count_byte();
    end else begin
      emit_conversion(scale_by_exponent(running_value), bytes_taken);
    end
  endfunction

  // predictor follows every accepted input transfer
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) scan_byte(s_tdata);
  end

  // result checker
  always @(posedge clk) begin
    conversion_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_conversions.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result %h", m_tdata);
      end else begin
        want = pending_conversions.pop_front();
        if (m_tdata[63:0] !== want.value_bits || m_tdata[79:64] !== want.end_offset) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: value %h offset %0d, expected value %h offset %0d",
                     m_tdata[63:0], m_tdata[79:64], want.value_bits, want.end_offset);
        end
      end
    end
  end

  // receiver: random stalls, or a counted hold-off
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (recv_hold > 0) begin
      m_tready <= 1'b0;
      recv_hold--;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // one byte transfer; entered and left at a falling edge
  task automatic send_byte(input logic [7:0] c);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (pending_conversions.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic logic [7:0] random_digit();
    return 8'd48 + 8'($urandom_range(9));
  endfunction

  // a byte that cannot continue any number phase
  function automatic logic [7:0] random_terminator();
    logic [7:0] c;
    do c = 8'($urandom_range(255));
    while (is_decimal(c) || c == "." || c == "+" || c == "-" || (c | 8'd32) == "e");
    return c;
  endfunction

  // number text with random content, sometimes with a broken exponent start; returns bytes sent
  task automatic send_random_number(output int sent);
    int n;
    sent = 0;
    n = $urandom_range(2);
    repeat (n) begin
      send_byte($urandom_range(1) ? 8'd32 : 8'($urandom_range(13, 9)));
      sent++;
    end
    if ($urandom_range(1)) begin
      send_byte($urandom_range(1) ? "-" : "+");
      sent++;
    end
    n = $urandom_range(7);
    repeat (n) begin send_byte(random_digit()); sent++; end
    if ($urandom_range(2) != 0) begin
      send_byte(".");
      sent++;
      n = $urandom_range(6);
      repeat (n) begin send_byte(random_digit()); sent++; end
    end
    if ($urandom_range(2) == 0) begin
      send_byte($urandom_range(1) ? "e" : "E");
      sent++;
      case ($urandom_range(9))
        0: begin send_byte(random_terminator()); sent++; end  // broken exponent start
        default: begin
          if ($urandom_range(1)) begin
            send_byte($urandom_range(1) ? "-" : "+");
            sent++;
          end
          n = $urandom_range(3);
          repeat (n) begin send_byte(random_digit()); sent++; end
        end
      endcase
    end
    if (scan_phase != SCAN_SPACE || $urandom_range(1)) begin
      send_byte(random_terminator());
      sent++;
    end
  endtask

  task automatic test_directed();
    send_idle_pct = 10;
    recv_idle_pct = 10;
    send_text("0 ");
    send_text("\t\n\v\f\r-123.456e-7;");
    send_text("+x");
    send_text("e5 ");
    send_text("1e+;");
    send_text("-1e!");          // broken exponent start with minus sign
    send_text("1e999 ");        // overflow to infinity
    send_text("2.5E-999 ");     // underflow to zero
    send_text("4.9e-324 ");     // subnormal
    send_text("0e400 ");        // zero times a scale beyond the double range
    send_text("-.5");
    send_byte(8'hFF);
    send_text(" 1.");
    send_byte(8'h80);
    send_text("- 7");
    send_byte(8'h00);
    send_text("99999999999999999999 ");
    wait_drained();
  endtask

  task automatic test_random(input int unsigned s_pct, input int unsigned r_pct,
                             input int budget);
    int sent;
    int total;
    total = 0;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    while (total < budget) begin
      if ($urandom_range(9) == 0) begin
        send_byte(8'($urandom_range(255)));   // noise
        total++;
      end else begin
        send_random_number(sent);
        total += sent;
      end
    end
    wait_drained();
  endtask

  task automatic test_back_pressure();
    int sent;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    recv_hold = 1500;
    repeat (12) begin
      send_random_number(sent);
      send_byte(";");
    end
    // sender pauses until every result is back, then resumes
    s_tvalid <= 1'b0;
    while (pending_conversions.size() != 0) @(negedge clk);
    send_text("3.25e2;");
    wait_drained();
  endtask

  initial begin
    clear_scan();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_random(28, 86, 400);
    test_random(86, 28, 400);
    test_random(0, 0, 400);
    test_back_pressure();
    if (mismatch_count == 0 && pending_conversions.size() == 0) begin
      $display("decimal_text_to_double_top test passed");
    end else begin
      $display("decimal_text_to_double_top test failed");
    end
    $finish;
  end

endmodule
